// ===== rtl/ws2812pbe_pkg.sv =====
// Shared types and constants for the WS2812 pixel bit encoder.
package ws2812pbe_pkg;

  localparam int TickW = 15;
  localparam int ColorW = 24;
  localparam int CfgIdxW = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegOneHigh  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOneLow   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegZeroHigh = 2'd2;
  localparam logic [CfgIdxW-1:0] RegZeroLow  = 2'd3;

  // Reset values (WS2812B timing)
  localparam logic [TickW-1:0] OneHighReset  = 15'd16;
  localparam logic [TickW-1:0] OneLowReset   = 15'd9;
  localparam logic [TickW-1:0] ZeroHighReset = 15'd8;
  localparam logic [TickW-1:0] ZeroLowReset  = 15'd17;

  typedef struct packed {
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] one_low;
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] zero_low;
  } timing_t;

endpackage

// ===== rtl/ws2812pbe_front.sv =====
// Front end: accepts pixels, packs them into the pulse word and stages them.
module ws2812pbe_front #(
  parameter int BITS_PER_PIXEL = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  input  logic                      last_pixel,
  output logic                      q_valid,
  input  logic                      q_ready,
  output logic [BITS_PER_PIXEL:0]   q_data
);
  import ws2812pbe_pkg::*;

  localparam int WideW = (BITS_PER_PIXEL > ColorW) ? BITS_PER_PIXEL : ColorW;

  logic [ColorW-1:0]         color;
  logic [WideW-1:0]          color_wide;
  logic [BITS_PER_PIXEL-1:0] word;
  logic                      stage_valid;
  logic [BITS_PER_PIXEL:0]   stage_data;

  // Pack red-green-blue; extra leading bits are zero, a short word drops top bits
  assign color      = {red, green, blue};
  assign color_wide = WideW'(color);
  assign word       = color_wide[BITS_PER_PIXEL-1:0];

  assign in_ready = !stage_valid || q_ready;
  assign q_valid  = stage_valid;
  assign q_data   = stage_data;

  // Staging register: {last mark, pulse word}
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_data <= {last_pixel, word};
    end
  end

endmodule

// ===== rtl/ws2812pbe_queue.sv =====
// Two-entry queue between the front end and the pulse generator.
module ws2812pbe_queue #(
  parameter int WIDTH = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/ws2812pbe_back.sv =====
// Back end: shifts each pixel word out as one timed pulse item per cycle while the output is taken.
module ws2812pbe_back #(
  parameter int BITS_PER_PIXEL = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ws2812pbe_pkg::timing_t        timing,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [BITS_PER_PIXEL:0]       q_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ws2812pbe_pkg::TickW-1:0] mark_ticks,
  output logic [ws2812pbe_pkg::TickW-1:0] space_ticks,
  output logic                          data_bit,
  output logic                          pixel_done,
  output logic                          frame_done
);
  import ws2812pbe_pkg::*;

  localparam int CntW = $clog2(BITS_PER_PIXEL + 1);

  logic                      active;
  logic [BITS_PER_PIXEL-1:0] shreg;
  logic [CntW-1:0]           bits_left;
  logic                      frame_flag;
  logic                      slot_free;
  logic                      emit;
  logic                      final_bit;
  logic                      cur_bit;

  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && active;
  assign final_bit = (bits_left == CntW'(1));
  assign cur_bit   = shreg[BITS_PER_PIXEL-1];
  // Next pixel loads as the final pulse of the current one goes out
  assign q_ready   = slot_free && (!active || final_bit);

  // Shifter and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      bits_left <= '0;
    end else if (q_valid && q_ready) begin
      active    <= 1'b1;
      bits_left <= CntW'(BITS_PER_PIXEL);
    end else if (emit) begin
      active    <= !final_bit;
      bits_left <= bits_left - CntW'(1);
    end
    if (q_valid && q_ready) begin
      shreg      <= q_data[BITS_PER_PIXEL-1:0];
      frame_flag <= q_data[BITS_PER_PIXEL];
    end else if (emit) begin
      shreg <= {shreg[BITS_PER_PIXEL-2:0], 1'b0};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= active;
    end
    if (emit) begin
      mark_ticks  <= cur_bit ? timing.one_high : timing.zero_high;
      space_ticks <= cur_bit ? timing.one_low  : timing.zero_low;
      data_bit    <= cur_bit;
      pixel_done  <= final_bit;
      frame_done  <= final_bit && frame_flag;
    end
  end

endmodule

// ===== rtl/ws2812_pixel_bit_encoder.sv =====
// Top level of the WS2812 pixel bit encoder: timing registers and the pipeline.
//
// Each accepted pixel (red, green, blue, last mark) becomes BITS_PER_PIXEL
// pulse items, most significant bit of red<<16|green<<8|blue first, one item
// per clock while the output is taken, so a pixel occupies BITS_PER_PIXEL
// bits (24 by default) of the pulse generator's shifter. Pixels queue in a
// staging register and a two-entry queue, so new pixels are accepted while
// pulses of earlier ones are still going out, and back-to-back pixels stream
// without a gap. Timing registers (index 0..3: one high, one low, zero high,
// zero low) reset to 16/9/8/17 ticks and should be written only while the
// encoder is idle.
module ws2812_pixel_bit_encoder #(
  parameter int BITS_PER_PIXEL = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [ws2812pbe_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ws2812pbe_pkg::TickW-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            red,
  input  logic [7:0]                            green,
  input  logic [7:0]                            blue,
  input  logic                                  last_pixel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ws2812pbe_pkg::TickW-1:0]       mark_ticks,
  output logic [ws2812pbe_pkg::TickW-1:0]       space_ticks,
  output logic                                  data_bit,
  output logic                                  pixel_done,
  output logic                                  frame_done
);
  import ws2812pbe_pkg::*;

  timing_t                 timing;
  logic                    fq_valid;
  logic                    fq_ready;
  logic [BITS_PER_PIXEL:0] fq_data;
  logic                    qb_valid;
  logic                    qb_ready;
  logic [BITS_PER_PIXEL:0] qb_data;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.one_high  <= OneHighReset;
      timing.one_low   <= OneLowReset;
      timing.zero_high <= ZeroHighReset;
      timing.zero_low  <= ZeroLowReset;
    end else if (cfg_write) begin
      case (cfg_index)
        RegOneHigh:  timing.one_high  <= cfg_data;
        RegOneLow:   timing.one_low   <= cfg_data;
        RegZeroHigh: timing.zero_high <= cfg_data;
        RegZeroLow:  timing.zero_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  ws2812pbe_front #(
    .BITS_PER_PIXEL(BITS_PER_PIXEL)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last_pixel (last_pixel),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_data     (fq_data)
  );

  ws2812pbe_queue #(
    .WIDTH(BITS_PER_PIXEL + 1)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  ws2812pbe_back #(
    .BITS_PER_PIXEL(BITS_PER_PIXEL)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .timing      (timing),
    .q_valid     (qb_valid),
    .q_ready     (qb_ready),
    .q_data      (qb_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mark_ticks  (mark_ticks),
    .space_ticks (space_ticks),
    .data_bit    (data_bit),
    .pixel_done  (pixel_done),
    .frame_done  (frame_done)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the WS2812 pixel bit encoder: directed pixels, then random frames.
`timescale 1ns / 100ps

module tb;
  import ws2812pbe_pkg::*;

  localparam int PulsesPerPixel = 24;
  localparam int DirectedRows = 18;
  localparam int TimingPhases = 6;
  localparam int PixelsPerPhase = 78;
  localparam int SettleCycles = 12;
  localparam int CycleLimit = 400000;
  localparam int ReportLimit = 10;
  localparam logic [TickW-1:0] TickMax = '1;

  // One pulse item as seen on the output
  typedef struct packed {
    logic [TickW-1:0] high;
    logic [TickW-1:0] low;
    logic             data_bit;
    logic             pixel_done;
    logic             frame_done;
  } pulse_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  // Directed row: uniform pixels carry their pulse timing typed in
  typedef struct packed {
    pixel_t           px;
    logic             typed;
    logic [TickW-1:0] high;
    logic [TickW-1:0] low;
    logic             data_bit;
  } directed_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = RegOneHigh;
  logic [TickW-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       red = '0;
  logic [7:0]       green = '0;
  logic [7:0]       blue = '0;
  logic             last_pixel = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [TickW-1:0] mark_ticks;
  logic [TickW-1:0] space_ticks;
  logic             data_bit;
  logic             pixel_done;
  logic             frame_done;

  // Predictor state and scoreboard
  timing_t       timing;
  pulse_t        pending_pulses [$];
  directed_row_t directed_table [DirectedRows];
  pulse_t        got_pulse;
  pulse_t        want_pulse;
  int            send_idle = 0;
  int            recv_idle = 0;
  int            mismatches = 0;
  int            pixels_sent = 0;
  int            pulses_checked = 0;
  int            cycles = 0;

  ws2812_pixel_bit_encoder DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_pixel  (last_pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mark_ticks  (mark_ticks),
    .space_ticks (space_ticks),
    .data_bit    (data_bit),
    .pixel_done  (pixel_done),
    .frame_done  (frame_done)
  );

  always #2 clk = ~clk;

  // Expected pulse train of one pixel, MSB of red first
  function automatic void encode_pixel(pixel_t px);
    logic [ColorW-1:0] rgb;
    pulse_t p;
    rgb = {px.red, px.green, px.blue};
    for (int i = PulsesPerPixel - 1; i >= 0; i--) begin
      p.data_bit   = rgb[i];
      p.high       = rgb[i] ? timing.one_high : timing.zero_high;
      p.low        = rgb[i] ? timing.one_low : timing.zero_low;
      p.pixel_done = (i == 0);
      p.frame_done = (i == 0) && px.last;
      pending_pulses.push_back(p);
    end
  endfunction

  // Uniform pixel whose every pulse is known up front
  function automatic void expect_uniform(directed_row_t row);
    pulse_t p;
    for (int i = PulsesPerPixel - 1; i >= 0; i--) begin
      p = {row.high, row.low, row.data_bit, i == 0, (i == 0) && row.px.last};
      pending_pulses.push_back(p);
    end
  endfunction

  function automatic string fmt_pulse(pulse_t p);
    return $sformatf("high %0d low %0d bit %b pixel_done %b frame_done %b",
                     p.high, p.low, p.data_bit, p.pixel_done, p.frame_done);
  endfunction

  function automatic void count_mismatch(string detail);
    mismatches++;
    if (mismatches <= ReportLimit) $display("MISMATCH at %0t ns: %s", $time, detail);
  endfunction

  // Bytes lean towards 00 and FF; roughly one pixel in eight closes a frame
  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [7:0] ch [3];
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(9))
        0: ch[c] = 8'h00;
        1: ch[c] = 8'hFF;
        default: ch[c] = 8'($urandom);
      endcase
    end
    px.red   = ch[0];
    px.green = ch[1];
    px.blue  = ch[2];
    px.last  = ($urandom_range(7) == 0);
    return px;
  endfunction

  // Present one pixel, idling at random first, and return once it is taken
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    red        <= px.red;
    green      <= px.green;
    blue       <= px.blue;
    last_pixel <= px.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Write all four timing registers back to back, then mirror them
  task automatic load_timing(input timing_t t);
    logic [TickW-1:0] vals [4];
    logic [CfgIdxW-1:0] idx [4];
    vals = '{t.one_high, t.one_low, t.zero_high, t.zero_low};
    idx  = '{RegOneHigh, RegOneLow, RegZeroHigh, RegZeroLow};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    timing = t;
  endtask

  // Wait for every pulse, then let the pipeline settle
  task automatic drain();
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Receiver: random back-pressure and the output check
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
    if (!rst && out_valid && out_ready) begin
      pulses_checked++;
      got_pulse = {mark_ticks, space_ticks, data_bit, pixel_done, frame_done};
      if (pending_pulses.size() == 0) begin
        count_mismatch({"unexpected pulse: ", fmt_pulse(got_pulse)});
      end else begin
        want_pulse = pending_pulses.pop_front();
        if (got_pulse !== want_pulse)
          count_mismatch({"expected ", fmt_pulse(want_pulse), " / got ", fmt_pulse(got_pulse)});
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("ws2812_pixel_bit_encoder: mismatch");
      $finish;
    end
  end

  initial begin
    pixel_t  px;
    timing_t setting;
    timing = {OneHighReset, OneLowReset, ZeroHighReset, ZeroLowReset};
    directed_table = '{
      '{'{8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, ZeroHighReset, ZeroLowReset, 1'b0},
      '{'{8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1, OneHighReset, OneLowReset, 1'b1},
      '{'{8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, ZeroHighReset, ZeroLowReset, 1'b0},
      '{'{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, OneHighReset, OneLowReset, 1'b1},
      '{'{8'h80, 8'h00, 8'h00, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'h00, 8'h00, 8'h01, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'hFF, 8'h00, 8'h00, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'h00, 8'hFF, 8'h00, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'h00, 8'h00, 8'hFF, 1'b1}, 1'b0, '0, '0, 1'b0},
      '{'{8'hAA, 8'h55, 8'hAA, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'h55, 8'hAA, 8'h55, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'h01, 8'h80, 8'hC3, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'h7F, 8'hFF, 8'hFE, 1'b1}, 1'b0, '0, '0, 1'b0},
      '{'{8'h12, 8'h34, 8'h56, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'hFE, 8'hDC, 8'hBA, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'h01, 8'h01, 8'h01, 1'b1}, 1'b0, '0, '0, 1'b0},
      '{'{8'h80, 8'h80, 8'h80, 1'b0}, 1'b0, '0, '0, 1'b0},
      '{'{8'h7F, 8'h7F, 8'h7F, 1'b1}, 1'b0, '0, '0, 1'b0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels on the reset timing
    send_idle = 8;
    recv_idle = 57;
    for (int r = 0; r < DirectedRows; r++) begin
      send_pixel(directed_table[r].px);
      if (directed_table[r].typed) expect_uniform(directed_table[r]);
      else encode_pixel(directed_table[r].px);
    end
    in_valid <= 1'b0;

    // Random frames, one timing setting per phase
    for (int ph = 0; ph < TimingPhases; ph++) begin
      drain();
      case (ph)
        0: setting = '0;
        1: setting = {TickMax, TickMax, TickMax, TickMax};
        2: setting = {TickMax, TickW'(0), TickW'(0), TickMax};
        3, 4: setting = {TickW'($urandom), TickW'($urandom),
                         TickW'($urandom), TickW'($urandom)};
        default: setting = {OneHighReset, OneLowReset, ZeroHighReset, ZeroLowReset};
      endcase
      load_timing(setting);
      if (ph < 2) begin
        send_idle = 8;
        recv_idle = 57;
      end else if (ph < 4) begin
        send_idle = 57;
        recv_idle = 8;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < PixelsPerPhase; n++) begin
        px = random_pixel();
        send_pixel(px);
        encode_pixel(px);
      end
      in_valid <= 1'b0;
    end
    drain();

    $display("Sent %0d pixels and compared %0d pulses across %0d timing settings,",
             pixels_sent, pulses_checked, TimingPhases + 1);
    $display("zero, full-scale and reset timing among them, under three back-pressure mixes.");
    if (mismatches == 0) begin
      $display("ws2812_pixel_bit_encoder: match");
    end else begin
      $display("%0d pulses disagreed", mismatches);
      $display("ws2812_pixel_bit_encoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ws2812pbe_pkg.sv
rtl/ws2812pbe_front.sv
rtl/ws2812pbe_queue.sv
rtl/ws2812pbe_back.sv
rtl/ws2812_pixel_bit_encoder.sv
verif/tb.sv
